>>> rtl/svm_ovo_pkg.sv
// ----------------------------------------------------------------------------
// svm_ovo_pkg
// Shared payload types and fixed-point helpers for the one-vs-one SVM engine.
// ----------------------------------------------------------------------------
`default_nettype none

package svm_ovo_pkg;

    // Input item opcodes
    localparam logic [1:0] OP_LOAD_COEF   = 2'd0;
    localparam logic [1:0] OP_LOAD_OFFSET = 2'd1;
    localparam logic [1:0] OP_LOAD_CLASS  = 2'd2;
    localparam logic [1:0] OP_KERNEL      = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [4:0]         slot;
        logic [9:0]         sv_index;
        logic signed [31:0] sample_value;
        logic [10:0]        vec_count;
        logic               row_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] decision_value;
        logic [4:0]         pair_index;
        logic               last_of_run;
    } t_out_item;

    // Handshake between front and back
    typedef struct packed {
        logic start;
        logic done;
    } t_pass_ctl;

    // Signed 64-bit add, clamped to the 64-bit range
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] sum;
        begin
            sum = {a[63], a} + {b[63], b};
            if (sum[64] != sum[63]) begin
                sat_add64 = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                sat_add64 = sum[63:0];
            end
        end
    endfunction

    // Q32.32 to Q16.16: add half an LSB, floor, clamp to 32 bits
    function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
        logic signed [48:0] q;
        begin
            q = {v[63], v[63:16]} + {48'd0, v[15]};
            if (q > 49'sd2147483647) begin
                to_q16 = 32'sh7fffffff;
            end else if (q < -49'sd2147483648) begin
                to_q16 = 32'sh80000000;
            end else begin
                to_q16 = q[31:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/svm_ovo_ram.sv
// ----------------------------------------------------------------------------
// svm_ovo_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ovo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/svm_ovo_front.sv
// ----------------------------------------------------------------------------
// svm_ovo_front
// Accepts input items, decodes them into store writes and starts a pass.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ovo_front #(
    parameter int MAX_CLASSES = 8,
    parameter int MAX_SV      = 1024,
    parameter int CL_W        = 3,
    parameter int SV_W        = 10,
    parameter int CA_W        = 13,
    parameter int PR_W        = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire svm_ovo_pkg::t_in_item  i_item,
    input  wire logic                   i_done,
    output logic                        o_start,
    output logic                        o_coef_we,
    output logic [CA_W-1:0]             o_coef_addr,
    output logic                        o_kern_we,
    output logic [SV_W-1:0]             o_kern_addr,
    output logic                        o_off_we,
    output logic [PR_W-1:0]             o_off_addr,
    output logic [31:0]                 o_wr_data,
    output logic [9:0]                  o_cls_start [MAX_CLASSES],
    output logic [10:0]                 o_cls_size  [MAX_CLASSES]
);

    import svm_ovo_pkg::*;

    localparam int ROWS  = MAX_CLASSES - 1;
    localparam int PAIRS = (MAX_CLASSES * (MAX_CLASSES - 1)) / 2;

    logic        r_wait, n_wait;
    logic        r_start;
    logic        accept;
    logic        pos_ok;
    logic [31:0] slot32;
    logic [9:0]  r_cls_start [MAX_CLASSES];
    logic [10:0] r_cls_size  [MAX_CLASSES];

    assign o_in_stall = r_wait;
    assign accept     = i_in_valid && !r_wait;
    assign slot32     = 32'(i_item.slot);
    assign pos_ok     = 32'(i_item.sv_index) < MAX_SV;

    // store write decode
    assign o_wr_data   = i_item.sample_value;
    assign o_coef_we   = accept && (i_item.opcode == OP_LOAD_COEF) && (slot32 < ROWS) && pos_ok;
    assign o_coef_addr = CA_W'(slot32 * MAX_SV + 32'(i_item.sv_index));
    assign o_kern_we   = accept && (i_item.opcode == OP_KERNEL) && pos_ok;
    assign o_kern_addr = SV_W'(i_item.sv_index);
    assign o_off_we    = accept && (i_item.opcode == OP_LOAD_OFFSET) && (slot32 < PAIRS);
    assign o_off_addr  = PR_W'(i_item.slot);

    // hold off further items from row end until the pass finishes
    always_comb begin
        n_wait = r_wait;
        if (accept && (i_item.opcode == OP_KERNEL) && i_item.row_end) begin
            n_wait = 1'b1;
        end else if (i_done) begin
            n_wait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait  <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_wait  <= n_wait;
            r_start <= accept && (i_item.opcode == OP_KERNEL) && i_item.row_end;
        end
    end

    assign o_start = r_start;

    // class range table
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.opcode == OP_LOAD_CLASS) && (slot32 < MAX_CLASSES)) begin
            r_cls_start[i_item.slot[CL_W-1:0]] <= i_item.sv_index;
            r_cls_size[i_item.slot[CL_W-1:0]]  <= i_item.vec_count;
        end
    end

    assign o_cls_start = r_cls_start;
    assign o_cls_size  = r_cls_size;

endmodule

`default_nettype wire

>>> rtl/svm_ovo_back.sv
// ----------------------------------------------------------------------------
// svm_ovo_back
// Pair sequencer with one pipelined multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ovo_back #(
    parameter int MAX_CLASSES = 8,
    parameter int MAX_SV      = 1024,
    parameter int CL_W        = 3,
    parameter int SV_W        = 10,
    parameter int CA_W        = 13,
    parameter int PR_W        = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [3:0]             i_num_classes,
    input  wire logic                   i_start,
    output logic                        o_done,
    output logic                        o_busy,
    input  wire logic [9:0]             i_cls_start [MAX_CLASSES],
    input  wire logic [10:0]            i_cls_size  [MAX_CLASSES],
    output logic [CA_W-1:0]             o_coef_addr,
    input  wire logic [31:0]            i_coef_data,
    output logic [SV_W-1:0]             o_kern_addr,
    input  wire logic [31:0]            i_kern_data,
    output logic [PR_W-1:0]             o_off_addr,
    input  wire logic [31:0]            i_off_data,
    output logic                        o_push,
    input  wire logic                   i_full,
    output svm_ovo_pkg::t_out_item      o_result
);

    import svm_ovo_pkg::*;

    localparam int PW = (SV_W + 1 > 12) ? SV_W + 1 : 12;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TERM  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_OFF   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]         r_state;
    logic [4:0]         r_i, r_j;
    logic               r_term;
    logic [10:0]        r_l;
    logic [PR_W-1:0]    r_k;
    logic               r_v1, r_v2;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic [4:0]         cls, row;
    logic [PW-1:0]      pos;
    logic               issue;
    logic               last_pair;
    logic [4:0]         nc;
    logic signed [63:0] off_q32;
    logic [31:0]        k32;

    assign nc = {1'b0, i_num_classes};

    // current term: class i with row j-1, then class j with row i
    assign cls   = r_term ? r_j : r_i;
    assign row   = r_term ? r_i : r_j - 5'd1;
    assign pos   = PW'(i_cls_start[cls[CL_W-1:0]]) + PW'(r_l);
    assign issue = (r_state == S_TERM) && (r_l < i_cls_size[cls[CL_W-1:0]])
                   && (32'(pos) < MAX_SV);

    assign o_coef_addr = CA_W'(32'(row) * MAX_SV + 32'(pos[SV_W-1:0]));
    assign o_kern_addr = pos[SV_W-1:0];
    assign o_off_addr  = r_k;

    assign last_pair = (r_i == nc - 5'd2);
    assign off_q32   = {{16{i_off_data[31]}}, i_off_data, 16'd0};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= 5'd1;
            r_term  <= 1'b0;
            r_l     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_TERM;
                        r_i     <= '0;
                        r_j     <= 5'd1;
                        r_term  <= 1'b0;
                        r_l     <= '0;
                        r_k     <= '0;
                    end
                end
                S_TERM: begin
                    if (issue) begin
                        r_l <= r_l + 11'd1;
                    end else if (!r_term) begin
                        r_term <= 1'b1;
                        r_l    <= '0;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_full) begin
                        if (last_pair) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_TERM;
                            r_term  <= 1'b0;
                            r_l     <= '0;
                            r_k     <= r_k + PR_W'(1);
                            if (r_j + 5'd1 < nc) begin
                                r_j <= r_j + 5'd1;
                            end else begin
                                r_i <= r_i + 5'd1;
                                r_j <= r_i + 5'd2;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // MAC valid pipeline: read data, product, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_coef_data) * $signed(i_kern_data);
    end

    // accumulator: cleared per pair, saturating adds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if ((r_state == S_IDLE && i_start) || (r_state == S_OUT && !i_full)) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= sat_add64(r_acc, r_prod);
        end else if (r_state == S_OFF) begin
            r_acc <= sat_add64(r_acc, -off_q32);
        end
    end

    assign k32                     = 32'(r_k);
    assign o_push                  = (r_state == S_OUT) && !i_full;
    assign o_done                  = o_push && last_pair;
    assign o_busy                  = (r_state != S_IDLE);
    assign o_result.decision_value = to_q16(r_acc);
    assign o_result.pair_index     = k32[4:0];
    assign o_result.last_of_run    = last_pair;

endmodule

`default_nettype wire

>>> rtl/svm_ovo_fifo.sv
// ----------------------------------------------------------------------------
// svm_ovo_fifo
// Four-entry result queue between the pair sequencer and the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ovo_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire svm_ovo_pkg::t_out_item i_data,
    output logic                        o_full,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output svm_ovo_pkg::t_out_item      o_data
);

    import svm_ovo_pkg::*;

    t_out_item  r_buf [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_buf[r_rd];
    assign pop     = o_valid && !i_stall;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/svm_one_vs_one_decision.sv
// ----------------------------------------------------------------------------
// svm_one_vs_one_decision
// One-vs-one multiclass SVM decision engine, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Load items are accepted one per cycle while the input is not stalled. A
// kernel item with row_end starts a pass; input stays stalled until the last
// pair result has entered the output queue. Pairs are processed one at a time
// by the single multiply-accumulate unit, which reads one coefficient and one
// kernel value per cycle, and each pair may wait for room in the output
// queue. Results leave through a four-entry queue.
`default_nettype none

module svm_one_vs_one_decision #(
    parameter int MAX_CLASSES = 8,
    parameter int MAX_SV      = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire svm_ovo_pkg::t_in_item  i_item,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output svm_ovo_pkg::t_out_item      o_item,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [3:0]             i_cfg_wr_data
);

    import svm_ovo_pkg::*;

    localparam int ROWS  = MAX_CLASSES - 1;
    localparam int PAIRS = (MAX_CLASSES * (MAX_CLASSES - 1)) / 2;
    localparam int CL_W  = $clog2(MAX_CLASSES);
    localparam int SV_W  = $clog2(MAX_SV);
    localparam int CA_W  = $clog2(ROWS * MAX_SV);
    localparam int PR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    logic [3:0]      r_num_classes;
    logic            start, done, busy;
    logic            coef_we, kern_we, off_we;
    logic [CA_W-1:0] coef_wa, coef_ra;
    logic [SV_W-1:0] kern_wa, kern_ra;
    logic [PR_W-1:0] off_wa, off_ra;
    logic [31:0]     wr_data, coef_rd, kern_rd, off_rd;
    logic [9:0]      cls_start [MAX_CLASSES];
    logic [10:0]     cls_size  [MAX_CLASSES];
    logic            push, full;
    t_out_item       result;
    t_pass_ctl       ctl;

    // class count register, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= 4'd2;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_wr_data < 4'd2) begin
                r_num_classes <= 4'd2;
            end else if (32'(i_cfg_wr_data) > MAX_CLASSES) begin
                r_num_classes <= 4'(MAX_CLASSES);
            end else begin
                r_num_classes <= i_cfg_wr_data;
            end
        end
    end

    assign ctl.start = start;
    assign ctl.done  = done;

    svm_ovo_front #(
        .MAX_CLASSES(MAX_CLASSES), .MAX_SV(MAX_SV), .CL_W(CL_W),
        .SV_W(SV_W), .CA_W(CA_W), .PR_W(PR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (i_item),
        .i_done      (ctl.done),
        .o_start     (start),
        .o_coef_we   (coef_we),
        .o_coef_addr (coef_wa),
        .o_kern_we   (kern_we),
        .o_kern_addr (kern_wa),
        .o_off_we    (off_we),
        .o_off_addr  (off_wa),
        .o_wr_data   (wr_data),
        .o_cls_start (cls_start),
        .o_cls_size  (cls_size)
    );

    svm_ovo_ram #(.WIDTH(32), .DEPTH(ROWS * MAX_SV), .AW(CA_W)) u_coef_ram (
        .i_clk(i_clk), .i_wr_en(coef_we), .i_wr_addr(coef_wa), .i_wr_data(wr_data),
        .i_rd_addr(coef_ra), .o_rd_data(coef_rd)
    );

    svm_ovo_ram #(.WIDTH(32), .DEPTH(MAX_SV), .AW(SV_W)) u_kern_ram (
        .i_clk(i_clk), .i_wr_en(kern_we), .i_wr_addr(kern_wa), .i_wr_data(wr_data),
        .i_rd_addr(kern_ra), .o_rd_data(kern_rd)
    );

    svm_ovo_ram #(.WIDTH(32), .DEPTH(PAIRS), .AW(PR_W)) u_off_ram (
        .i_clk(i_clk), .i_wr_en(off_we), .i_wr_addr(off_wa), .i_wr_data(wr_data),
        .i_rd_addr(off_ra), .o_rd_data(off_rd)
    );

    svm_ovo_back #(
        .MAX_CLASSES(MAX_CLASSES), .MAX_SV(MAX_SV), .CL_W(CL_W),
        .SV_W(SV_W), .CA_W(CA_W), .PR_W(PR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_num_classes (r_num_classes),
        .i_start       (ctl.start),
        .o_done        (done),
        .o_busy        (busy),
        .i_cls_start   (cls_start),
        .i_cls_size    (cls_size),
        .o_coef_addr   (coef_ra),
        .i_coef_data   (coef_rd),
        .o_kern_addr   (kern_ra),
        .i_kern_data   (kern_rd),
        .o_off_addr    (off_ra),
        .i_off_data    (off_rd),
        .o_push        (push),
        .i_full        (full),
        .o_result      (result)
    );

    svm_ovo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_item)
    );

`ifndef SYNTHESIS
    // no input transfer while a pass is running
    a_no_accept_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_in_stall)
        else $error("input transfer during pass");

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("result queue overflow");

    // a pass start always finds the sequencer idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("pass start while busy");
`endif

endmodule

`default_nettype wire

>>> test/svm_ovo_checker.sv
// ----------------------------------------------------------------------------
// svm_ovo_checker
// Watches both channels of the one-vs-one SVM engine, predicts the pair
// decision values from the accepted input transfers and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ovo_checker (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire svm_ovo_pkg::t_in_item  i_item,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire svm_ovo_pkg::t_out_item i_res,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [3:0]             i_cfg_wr_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import svm_ovo_pkg::*;

    localparam int NCLS  = 8;
    localparam int NSV   = 1024;
    localparam int NROWS = NCLS - 1;
    localparam int NPAIR = NCLS * (NCLS - 1) / 2;

    // Model copy of the engine's stores
    logic signed [31:0] coef_mem [NROWS*NSV];
    logic signed [31:0] kern_mem [NSV];
    logic signed [31:0] offs_mem [NPAIR];
    logic [9:0]         cls_first [NCLS];
    logic [10:0]        cls_len   [NCLS];
    int                 class_cnt;

    t_out_item          pair_q [$];

    assign o_pending = pair_q.size();

    // Saturating 64-bit add
    function automatic logic signed [63:0] clamp_sum(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // Dot product of one coefficient row with one class's kernel values
    function automatic logic signed [63:0] class_dot(logic signed [63:0] acc,
                                                     int row, int cls);
        int p;
        for (int l = 0; l < cls_len[cls]; l++) begin
            p = cls_first[cls] + l;
            if (p >= NSV) break;
            acc = clamp_sum(acc, 64'(coef_mem[row*NSV + p]) * 64'(kern_mem[p]));
        end
        return acc;
    endfunction

    // Round Q32.32 to Q16.16 with saturation
    function automatic logic signed [31:0] round_q16(logic signed [63:0] v);
        logic signed [48:0] q;
        q = 49'(v >>> 16) + 49'(v[15]);
        if (q > 49'sd2147483647) return 32'sh7fffffff;
        if (q < -49'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    // Queue one result per class pair
    task automatic run_pass();
        logic signed [63:0] acc;
        t_out_item          r;
        int                 k;
        int                 npairs;
        npairs = class_cnt * (class_cnt - 1) / 2;
        k = 0;
        for (int i = 0; i < class_cnt; i++) begin
            for (int j = i + 1; j < class_cnt; j++) begin
                acc = class_dot(64'sd0, j - 1, i);
                acc = class_dot(acc, i, j);
                acc = clamp_sum(acc, -(64'(offs_mem[k]) <<< 16));
                r.decision_value = round_q16(acc);
                r.pair_index     = 5'(k);
                r.last_of_run    = (k + 1 == npairs);
                pair_q.insert(pair_q.size(), r);
                k++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            class_cnt    <= 2;
            o_fail_count <= 0;
        end else begin
            // Register write
            if (i_cfg_wr_en) begin
                class_cnt <= (i_cfg_wr_data < 2) ? 2 :
                             (i_cfg_wr_data > NCLS) ? NCLS : int'(i_cfg_wr_data);
            end
            // Input transfer updates the model
            if (i_in_valid && !i_in_stall) begin
                case (i_item.opcode)
                    OP_LOAD_COEF:
                        if (i_item.slot < NROWS)
                            coef_mem[i_item.slot*NSV + i_item.sv_index] = i_item.sample_value;
                    OP_LOAD_OFFSET:
                        if (i_item.slot < NPAIR) offs_mem[i_item.slot] = i_item.sample_value;
                    OP_LOAD_CLASS:
                        if (i_item.slot < NCLS) begin
                            cls_first[i_item.slot] = i_item.sv_index;
                            cls_len[i_item.slot]   = i_item.vec_count;
                        end
                    default: begin
                        kern_mem[i_item.sv_index] = i_item.sample_value;
                        if (i_item.row_end) run_pass();
                    end
                endcase
            end
            // Result transfer is compared with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (pair_q.size() == 0) begin
                    $error("unexpected result pair_index=%0d", i_res.pair_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    t_out_item e;
                    e = pair_q.pop_front();
                    if (e != i_res) o_fail_count <= o_fail_count + 1;
                    if (e.decision_value != i_res.decision_value)
                        $error("decision_value exp %0d got %0d",
                               e.decision_value, i_res.decision_value);
                    if (e.pair_index != i_res.pair_index)
                        $error("pair_index exp %0d got %0d", e.pair_index, i_res.pair_index);
                    if (e.last_of_run != i_res.last_of_run)
                        $error("last_of_run exp %0d got %0d",
                               e.last_of_run, i_res.last_of_run);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives load and kernel transfers into the one-vs-one SVM engine over
// several class counts, with random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import svm_ovo_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = 4'd0;
    int         fail_count;
    int         pending;
    int         burst_left = 0;
    int         ncls = 2;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    svm_one_vs_one_decision DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_item(out_item),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data)
    );

    svm_ovo_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_res(out_item),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stall pattern: drawn at random on every falling edge; stalls are rare
    always @(negedge i_clk) begin
        if (($urandom % 64) < 40) out_stall <= 1'b0;
        else out_stall <= ($urandom % 3) == 0;
    end

    // Send one transfer; valid stays high inside a burst and drops in a gap
    task automatic send(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [1:0] op, input int slot, input int pos,
                           input logic [31:0] val, input int cnt, input bit last);
        t_in_item it;
        it.opcode = op; it.slot = 5'(slot); it.sv_index = 10'(pos);
        it.sample_value = val; it.vec_count = 11'(cnt); it.row_end = last;
        send(it);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom % 6)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_classes(input logic [3:0] v);
        wait_idle();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        ncls = (v < 2) ? 2 : (v > 8) ? 8 : v;
    endtask

    // Fill every store the pass reads for the current class count,
    // using small class ranges
    task automatic load_model(input bit extreme);
        int first [8];
        int len [8];
        for (int c = 0; c < ncls; c++) begin
            len[c]   = extreme ? ((c == 0) ? 2 : 1) : $urandom_range(0, (ncls > 4) ? 1 : 2);
            first[c] = (c == ncls - 1) ? 1024 - len[c] + $urandom_range(0, 2)
                                       : $urandom_range(0, 1023 - len[c]);
            if (first[c] > 1023) first[c] = 1023;
            send_op(OP_LOAD_CLASS, c, first[c], $urandom, len[c], 1'($urandom));
        end
        for (int c = 0; c < ncls; c++)
            for (int l = 0; l < len[c] && first[c] + l < 1024; l++)
                for (int r = 0; r < ncls - 1; r++)
                    send_op(OP_LOAD_COEF, r, first[c] + l,
                            extreme ? 32'h7fffffff : rnd_val(), 0, 1'($urandom));
        for (int k = 0; k < ncls * (ncls - 1) / 2; k++)
            send_op(OP_LOAD_OFFSET, k, $urandom, extreme ? 32'h80000000 : rnd_val(),
                    $urandom, 1'($urandom));
        // Kernel values for every vector used, then one extra random kernel item with row_end
        for (int c = 0; c < ncls; c++)
            for (int l = 0; l < len[c] && first[c] + l < 1024; l++)
                send_op(OP_KERNEL, 0, first[c] + l,
                        extreme ? 32'h7fffffff : rnd_val(), 0, 1'b0);
        send_op(OP_KERNEL, $urandom, $urandom, rnd_val(), $urandom, 1'b1);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: out-of-range loads, then an all-extreme pass with two classes
        send_op(OP_LOAD_COEF, 7, 5, 32'h12345678, 0, 1'b1);
        send_op(OP_LOAD_COEF, 31, 1023, 32'h80000000, 2047, 1'b0);
        send_op(OP_LOAD_OFFSET, 28, 0, 32'hffffffff, 0, 1'b1);
        send_op(OP_LOAD_CLASS, 8, 1023, 32'h0, 1024, 1'b1);
        send_op(OP_LOAD_CLASS, 31, 0, 32'h0, 0, 1'b0);
        load_model(1'b1);

        // Class counts including clamped and extreme register values
        set_classes(4'd15); load_model(1'b0);
        set_classes(4'd0);  load_model(1'b0);
        set_classes(4'd1);  load_model(1'b0);

        // Random phases: small class counts
        for (int ph = 0; ph < 4; ph++) begin
            set_classes(4'($urandom_range(0, 4)));
            load_model(1'b0);
            // Extra kernel rows reusing loaded stores
            repeat ($urandom_range(0, 2)) send_op(OP_KERNEL, $urandom, $urandom,
                                                  rnd_val(), $urandom, 1'b1);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Timeout
    initial begin
        #4000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
